FILE: sv/dsc_pkg.sv
// ----------------------------------------------------------------------------
// Degree sine / cosine package
// Fixed widths, constants, pipeline payload types and step functions shared
// by the degree sine / cosine datapath.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Port formats.
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned WORK_BITS   = 32;
  localparam int unsigned ANG_W       = 32;
  localparam int unsigned OUT_W       = FRAC_BITS + 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // Angle reduction into 0..360 degrees.
  localparam int unsigned RED_W         = 25;
  localparam int unsigned RX_W          = 33;
  localparam int unsigned RED_STAGES    = 4;
  localparam int unsigned RED_PER_STAGE = 2;
  localparam logic [RED_W-1:0] PERIOD   = RED_W'(360 << FRAC_BITS);
  localparam logic [RED_W-1:0] DEG90    = RED_W'(90 << FRAC_BITS);
  localparam logic [RED_W-1:0] DEG270   = RED_W'(270 << FRAC_BITS);
  // 128 periods lift every input angle to a positive value below 256 periods.
  localparam logic [33:0] RED_OFFS      = 34'(64'd128 * 64'(PERIOD));

  // Degree to radian conversion, round(pi/180 * 2^32).
  localparam logic [26:0] DEG_TO_RAD = 27'd74961321;
  localparam int unsigned PRAD_W     = 52;
  localparam int unsigned THETA_W    = 35;
  localparam int unsigned TH_LO_W    = 18;
  localparam int unsigned THP_LO_W   = TH_LO_W + THETA_W;
  localparam int unsigned THP_HI_W   = THETA_W - TH_LO_W + THETA_W;
  localparam int unsigned THP_W      = 2 * THETA_W;
  localparam int unsigned TH2_W      = 38;

  // Taylor term recurrence.
  localparam int unsigned TERM_W    = 39;
  localparam int unsigned TERM_LO_W = 20;
  localparam int unsigned PLO_W     = TERM_LO_W + TH2_W;
  localparam int unsigned PHI_W     = TERM_W - TERM_LO_W + TH2_W;
  localparam int unsigned PROD_W    = TERM_W + TH2_W;
  localparam int unsigned X_W       = PROD_W - WORK_BITS;
  localparam int unsigned X_LO_W    = 23;
  localparam int unsigned RCP_W     = 43;
  localparam int unsigned RCP_SHIFT = 45;
  localparam int unsigned RLO_W     = X_LO_W + RCP_W;
  localparam int unsigned RHI_W     = X_W - X_LO_W + RCP_W;
  localparam int unsigned RFULL_W   = X_W + RCP_W;
  localparam int unsigned Q0_W      = RFULL_W - RCP_SHIFT;
  localparam int unsigned DIV_W     = 11;
  localparam int unsigned QD_W      = Q0_W + DIV_W;
  localparam int unsigned SUM_W     = 48;

  // Square root.
  localparam int unsigned SQR_W          = 35;
  localparam int unsigned ROOT_W         = 32;
  localparam int unsigned SQRT_STAGES    = 16;
  localparam int unsigned SQRT_PER_STAGE = 2;

  // Payload that rides along the series stages.
  typedef struct packed {
    logic                    act;
    logic                    cneg;
    logic [TH2_W-1:0]        th2;
    logic signed [SUM_W-1:0] sum;
  } dsc_ctx_t;

  // Payload that rides along the cosine stages.
  typedef struct packed {
    logic                    act;
    logic                    cneg;
    logic                    one;
    logic signed [SUM_W-1:0] v;
  } dsc_fin_t;

  // Digit-by-digit square root state.
  typedef struct packed {
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] xr;
  } dsc_sq_t;

  // One compare-subtract step of the modulo by 360 degrees.
  function automatic logic [RX_W-1:0] red_step(logic [RX_W-1:0] x, int unsigned k);
    logic [RX_W-1:0] sub;
    sub = RX_W'(PERIOD) << k;
    return (x >= sub) ? (x - sub) : x;
  endfunction

  // One result bit of the floor square root; two radicand bits enter per step.
  function automatic dsc_sq_t sqrt_step(dsc_sq_t s);
    logic [SQR_W+1:0] rem2;
    logic [SQR_W-1:0] trial;
    dsc_sq_t          r;
    rem2  = {s.rem, s.xr[ROOT_W-1 -: 2]};
    trial = SQR_W'({s.root, 2'b01});
    if (rem2 >= {2'b00, trial}) begin
      r.rem  = SQR_W'(rem2 - {2'b00, trial});
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = SQR_W'(rem2);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.xr = {s.xr[ROOT_W-3:0], 2'b00};
    return r;
  endfunction

endpackage

FILE: sv/degree_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// Degree sine / cosine evaluator
// Pipelined sine or cosine of a Q16.16 angle in degrees, Q1.16 result.
// ----------------------------------------------------------------------------
// The block takes one angle beat per clock and returns one result beat per
// angle, in order. An accepted input beat passes in turn through angle
// reduction and radian conversion, one slice for every series term after the
// first (a split multiply for term times theta squared, a split reciprocal
// multiply for the constant division and a correction step), the sum and the
// squaring, the square root at two bits per stage, rounding and the output
// register. A two-entry output buffer lets one more beat enter while a result
// waits; the input stalls only once both entries are full.
module degree_sine_cosine_top #(
  parameter int unsigned SERIES_TERMS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] angle_degrees
  input  logic [dsc_pkg::ANG_W-1:0]        s_axis_tdata_i,
  // [0] action
  input  logic [0:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [17:0] value, [23:18] zero
  output logic [dsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import dsc_pkg::*;

  logic en;
  logic skid_v_q;

  // The whole pipeline moves while the spare output entry is free.
  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  // Input stage: offset the angle so that the modulo works on a positive value.
  logic            s0_v_q, s0_act_q, s0_pos_q;
  logic [RX_W-1:0] s0_x_q;
  logic [33:0]     s0_sum;

  assign s0_sum = 34'($signed(s_axis_tdata_i)) + RED_OFFS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_act_q <= s_axis_tuser_i[0];
      s0_pos_q <= !s_axis_tdata_i[ANG_W-1] && (s_axis_tdata_i != '0);
      s0_x_q   <= s0_sum[RX_W-1:0];
    end
  end

  // Modulo by 360 degrees, two compare-subtract steps per stage.
  logic            rd_v   [RED_STAGES+1];
  logic            rd_act [RED_STAGES+1];
  logic            rd_pos [RED_STAGES+1];
  logic [RX_W-1:0] rd_x   [RED_STAGES+1];

  assign rd_v[0]   = s0_v_q;
  assign rd_act[0] = s0_act_q;
  assign rd_pos[0] = s0_pos_q;
  assign rd_x[0]   = s0_x_q;

  for (genvar gr = 0; gr < RED_STAGES; gr++) begin : g_red
    logic            v_q, act_q, pos_q;
    logic [RX_W-1:0] x_q;
    logic [RX_W-1:0] x_d;

    // Each stage removes the period scaled by the next two powers of two.
    always_comb begin
      x_d = rd_x[gr];
      for (int s = 0; s < RED_PER_STAGE; s++) begin
        x_d = red_step(x_d, (RED_STAGES - 1 - gr) * RED_PER_STAGE + RED_PER_STAGE - 1 - s);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= rd_v[gr];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        act_q <= rd_act[gr];
        pos_q <= rd_pos[gr];
        x_q   <= x_d;
      end
    end

    assign rd_v[gr+1]   = v_q;
    assign rd_act[gr+1] = act_q;
    assign rd_pos[gr+1] = pos_q;
    assign rd_x[gr+1]   = x_q;
  end

  // An exact positive multiple of 360 stays 360; start the radian product.
  logic              s5_v_q, s5_act_q, s5_cneg_q;
  logic [PRAD_W-1:0] s5_prod_q;
  logic [RED_W-1:0]  s5_red;
  logic [RED_W-1:0]  s5_red_q;

  assign s5_red = ((rd_x[RED_STAGES] == '0) && rd_pos[RED_STAGES]) ?
                  PERIOD : rd_x[RED_STAGES][RED_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= rd_v[RED_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_act_q  <= rd_act[RED_STAGES];
      s5_cneg_q <= (s5_red > DEG90) && (s5_red < DEG270);
      s5_red_q  <= s5_red;
      s5_prod_q <= PRAD_W'(s5_red) * PRAD_W'(DEG_TO_RAD);
    end
  end

  // Round the radian product to Q.32.
  logic               s6_v_q, s6_act_q, s6_cneg_q;
  logic [THETA_W-1:0] s6_theta_q;
  logic [PRAD_W-1:0]  s6_sum;

  assign s6_sum = s5_prod_q + PRAD_W'(1 << (FRAC_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_act_q   <= s5_act_q;
      s6_cneg_q  <= s5_cneg_q;
      s6_theta_q <= s6_sum[FRAC_BITS+THETA_W-1:FRAC_BITS];
    end
  end

  // Theta squared as two partial products.
  logic                s7_v_q, s7_act_q, s7_cneg_q;
  logic [THETA_W-1:0]  s7_theta_q;
  logic [THP_LO_W-1:0] s7_lo_q;
  logic [THP_HI_W-1:0] s7_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_act_q   <= s6_act_q;
      s7_cneg_q  <= s6_cneg_q;
      s7_theta_q <= s6_theta_q;
      s7_lo_q    <= THP_LO_W'(s6_theta_q[TH_LO_W-1:0]) * THP_LO_W'(s6_theta_q);
      s7_hi_q    <= THP_HI_W'(s6_theta_q[THETA_W-1:TH_LO_W]) * THP_HI_W'(s6_theta_q);
    end
  end

  // Combine and round theta squared; the first term is theta itself.
  logic              s8_v_q;
  dsc_ctx_t          s8_ctx_q;
  logic [TERM_W-1:0] s8_term_q;
  logic [THP_W-1:0]  s8_full;

  assign s8_full = THP_W'(s7_lo_q) + (THP_W'(s7_hi_q) << TH_LO_W) +
                   (THP_W'(1) << (WORK_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_ctx_q.act  <= s7_act_q;
      s8_ctx_q.cneg <= s7_cneg_q;
      s8_ctx_q.th2  <= s8_full[THP_W-1:WORK_BITS];
      s8_ctx_q.sum  <= '0;
      s8_term_q     <= TERM_W'(s7_theta_q);
    end
  end

  // Series terms: one five-stage slice per term after the first.
  logic              it_v    [SERIES_TERMS];
  dsc_ctx_t          it_ctx  [SERIES_TERMS];
  logic [TERM_W-1:0] it_term [SERIES_TERMS];

  assign it_v[0]    = s8_v_q;
  assign it_ctx[0]  = s8_ctx_q;
  assign it_term[0] = s8_term_q;

  for (genvar gi = 1; gi < SERIES_TERMS; gi++) begin : g_term
    localparam int unsigned      Div  = (2 * gi) * (2 * gi + 1);
    localparam logic [RCP_W-1:0] Rcp  = RCP_W'((89'd1 << RCP_SHIFT) / Div);
    localparam bit               Add  = (gi % 2) == 1;

    logic                    a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
    dsc_ctx_t                a_ctx_q, b_ctx_q, c_ctx_q, d_ctx_q, e_ctx_q;
    dsc_ctx_t                a_ctx_d;
    logic signed [SUM_W-1:0] a_tx;
    logic [PLO_W-1:0]        a_plo_q;
    logic [PHI_W-1:0]        a_phi_q;
    logic [PROD_W-1:0]       b_full;
    logic [X_W-1:0]          b_x_q, c_x_q, d_x_q;
    logic [RLO_W-1:0]        c_rlo_q;
    logic [RHI_W-1:0]        c_rhi_q;
    logic [RFULL_W-1:0]      d_full;
    logic [Q0_W-1:0]         d_q0_q;
    logic [QD_W-1:0]         e_qd;
    logic [X_W-1:0]          e_rem;
    logic [Q0_W-1:0]         e_q;
    logic [TERM_W-1:0]       e_term_q;

    // Stage A: fold the incoming term into the sum, multiply it by theta^2.
    assign a_tx = $signed(SUM_W'(it_term[gi-1]));

    always_comb begin
      a_ctx_d     = it_ctx[gi-1];
      a_ctx_d.sum = Add ? (it_ctx[gi-1].sum + a_tx) : (it_ctx[gi-1].sum - a_tx);
    end

    // Stage B: rounded product. Stage D: truncated reciprocal quotient.
    assign b_full = PROD_W'(a_plo_q) + (PROD_W'(a_phi_q) << TERM_LO_W) +
                    (PROD_W'(1) << (WORK_BITS - 1));
    assign d_full = RFULL_W'(c_rlo_q) + (RFULL_W'(c_rhi_q) << X_LO_W);

    // Stage E: the quotient is low by at most one; fix it from the remainder.
    assign e_qd  = QD_W'(d_q0_q) * QD_W'(DIV_W'(Div));
    assign e_rem = d_x_q - e_qd[X_W-1:0];
    assign e_q   = d_q0_q + Q0_W'(e_rem >= X_W'(Div));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q <= 1'b0;
        b_v_q <= 1'b0;
        c_v_q <= 1'b0;
        d_v_q <= 1'b0;
        e_v_q <= 1'b0;
      end else if (en) begin
        a_v_q <= it_v[gi-1];
        b_v_q <= a_v_q;
        c_v_q <= b_v_q;
        d_v_q <= c_v_q;
        e_v_q <= d_v_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_ctx_q  <= a_ctx_d;
        a_plo_q  <= PLO_W'(it_term[gi-1][TERM_LO_W-1:0]) * PLO_W'(it_ctx[gi-1].th2);
        a_phi_q  <= PHI_W'(it_term[gi-1][TERM_W-1:TERM_LO_W]) * PHI_W'(it_ctx[gi-1].th2);
        b_ctx_q  <= a_ctx_q;
        b_x_q    <= b_full[PROD_W-1:WORK_BITS];
        c_ctx_q  <= b_ctx_q;
        c_x_q    <= b_x_q;
        c_rlo_q  <= RLO_W'(b_x_q[X_LO_W-1:0]) * RLO_W'(Rcp);
        c_rhi_q  <= RHI_W'(b_x_q[X_W-1:X_LO_W]) * RHI_W'(Rcp);
        d_ctx_q  <= c_ctx_q;
        d_x_q    <= c_x_q;
        d_q0_q   <= d_full[RFULL_W-1:RCP_SHIFT];
        e_ctx_q  <= d_ctx_q;
        e_term_q <= e_q[TERM_W-1:0];
      end
    end

    assign it_v[gi]    = e_v_q;
    assign it_ctx[gi]  = e_ctx_q;
    assign it_term[gi] = e_term_q;
  end

  // Add the last term to finish the sine.
  localparam bit LastAdd = (SERIES_TERMS % 2) == 1;

  logic                    f0_v_q;
  dsc_fin_t                f0_fin_q;
  logic signed [SUM_W-1:0] f0_tx;

  assign f0_tx = $signed(SUM_W'(it_term[SERIES_TERMS-1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
    end else if (en) begin
      f0_v_q <= it_v[SERIES_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_fin_q.act  <= it_ctx[SERIES_TERMS-1].act;
      f0_fin_q.cneg <= it_ctx[SERIES_TERMS-1].cneg;
      f0_fin_q.one  <= 1'b0;
      f0_fin_q.v    <= LastAdd ? (it_ctx[SERIES_TERMS-1].sum + f0_tx) :
                                 (it_ctx[SERIES_TERMS-1].sum - f0_tx);
    end
  end

  // Sine magnitude; anything at or above 1.0 makes the radicand zero.
  logic                 f1_v_q, f1_big_q;
  dsc_fin_t             f1_fin_q;
  logic [WORK_BITS-1:0] f1_a_q;
  logic [SUM_W-1:0]     f1_abs;

  assign f1_abs = f0_fin_q.v[SUM_W-1] ? SUM_W'(-f0_fin_q.v) : SUM_W'(f0_fin_q.v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= f0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_fin_q <= f0_fin_q;
      f1_big_q <= (f1_abs[SUM_W-1:WORK_BITS] != '0);
      f1_a_q   <= f1_abs[WORK_BITS-1:0];
    end
  end

  // Square of the sine.
  logic                   f2_v_q, f2_big_q;
  dsc_fin_t               f2_fin_q;
  logic [2*WORK_BITS-1:0] f2_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_v_q <= 1'b0;
    end else if (en) begin
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_fin_q <= f1_fin_q;
      f2_big_q <= f1_big_q;
      f2_sq_q  <= (2*WORK_BITS)'(f1_a_q) * (2*WORK_BITS)'(f1_a_q);
    end
  end

  // Radicand 1 - sin^2; a zero square gives exactly 1.0 without the root.
  logic                 f3_v_q;
  dsc_fin_t             f3_fin_q;
  dsc_sq_t              f3_sq_q;
  logic [2*WORK_BITS:0] f3_rsum;
  logic [WORK_BITS:0]   f3_sqr;
  logic [WORK_BITS:0]   f3_rad;

  assign f3_rsum = (2*WORK_BITS+1)'(f2_sq_q) + (2*WORK_BITS+1)'(64'd1 << (WORK_BITS - 1));
  assign f3_sqr  = f3_rsum[2*WORK_BITS:WORK_BITS];
  assign f3_rad  = f2_big_q ? '0 : ((WORK_BITS+1)'(1) << WORK_BITS) - f3_sqr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_v_q <= 1'b0;
    end else if (en) begin
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f3_fin_q.act  <= f2_fin_q.act;
      f3_fin_q.cneg <= f2_fin_q.cneg;
      f3_fin_q.v    <= f2_fin_q.v;
      f3_fin_q.one  <= !f2_big_q && (f3_sqr == '0);
      f3_sq_q.rem   <= '0;
      f3_sq_q.root  <= '0;
      f3_sq_q.xr    <= f3_rad[WORK_BITS-1:0];
    end
  end

  // Floor square root of the radicand in Q.64, two result bits per stage.
  logic     sr_v   [SQRT_STAGES+1];
  dsc_fin_t sr_fin [SQRT_STAGES+1];
  dsc_sq_t  sr_sq  [SQRT_STAGES+1];

  assign sr_v[0]   = f3_v_q;
  assign sr_fin[0] = f3_fin_q;
  assign sr_sq[0]  = f3_sq_q;

  for (genvar gs = 0; gs < SQRT_STAGES; gs++) begin : g_sqrt
    logic     v_q;
    dsc_fin_t fin_q;
    dsc_sq_t  sq_q;
    dsc_sq_t  sq_d;

    always_comb begin
      sq_d = sr_sq[gs];
      for (int s = 0; s < SQRT_PER_STAGE; s++) begin
        sq_d = sqrt_step(sq_d);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= sr_v[gs];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fin_q <= sr_fin[gs];
        sq_q  <= sq_d;
      end
    end

    assign sr_v[gs+1]   = v_q;
    assign sr_fin[gs+1] = fin_q;
    assign sr_sq[gs+1]  = sq_q;
  end

  // Pick sine or signed cosine as sign and magnitude.
  logic               g1_v_q, g1_neg_q;
  logic [SUM_W-1:0]   g1_mag_q;
  logic [WORK_BITS:0] g1_c;
  dsc_fin_t           g1_in;

  assign g1_in = sr_fin[SQRT_STAGES];
  assign g1_c  = g1_in.one ? ((WORK_BITS+1)'(1) << WORK_BITS) :
                             (WORK_BITS+1)'(sr_sq[SQRT_STAGES].root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
    end else if (en) begin
      g1_v_q <= sr_v[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (g1_in.act) begin
        g1_neg_q <= g1_in.cneg;
        g1_mag_q <= SUM_W'(g1_c);
      end else begin
        g1_neg_q <= g1_in.v[SUM_W-1];
        g1_mag_q <= g1_in.v[SUM_W-1] ? SUM_W'(-g1_in.v) : SUM_W'(g1_in.v);
      end
    end
  end

  // Round half away from zero to Q1.16 and saturate at 1.0.
  localparam int unsigned RND_W = SUM_W + 1;

  logic                                   g2_v_q;
  logic [OUT_W-1:0]                       g2_val_q;
  logic [RND_W-1:0]                       g2_rnd;
  logic [RND_W-WORK_BITS+FRAC_BITS-1:0]   g2_m;
  logic [FRAC_BITS:0]                     g2_sat;

  assign g2_rnd = RND_W'(g1_mag_q) + RND_W'(1 << (WORK_BITS - FRAC_BITS - 1));
  assign g2_m   = g2_rnd[RND_W-1:WORK_BITS-FRAC_BITS];
  assign g2_sat = (g2_m > (RND_W-WORK_BITS+FRAC_BITS)'(1 << FRAC_BITS)) ?
                  (FRAC_BITS+1)'(1 << FRAC_BITS) : g2_m[FRAC_BITS:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g2_v_q <= 1'b0;
    end else if (en) begin
      g2_v_q <= g1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_val_q <= g1_neg_q ? OUT_W'(-OUT_W'(g2_sat)) : OUT_W'(g2_sat);
    end
  end

  // Output register with one spare entry behind it.
  logic             out_v_q;
  logic [OUT_W-1:0] out_val_q, skid_val_q;
  logic             push, pop;

  assign push = en && g2_v_q;
  assign pop  = out_v_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_val_q <= skid_val_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_val_q <= g2_val_q;
      end else begin
        out_val_q <= g2_val_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W-OUT_W)'(0), out_val_q};

  // The spare entry is only ever filled behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("output buffer spare entry holds a beat while the output is empty");

  // After a finished beat leaves the pipeline, the output holds a valid beat next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> out_v_q)
    else $error("finished beat lost between pipeline and output");

  // The reduced angle never exceeds one full turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s5_v_q |-> (s5_red_q <= PERIOD))
    else $error("angle reduction left a value above 360 degrees");

  // Results stay within -1.0 .. +1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (($signed(out_val_q) <= $signed(OUT_W'(1 << FRAC_BITS))) &&
                 ($signed(out_val_q) >= $signed(OUT_W'(-(1 << FRAC_BITS))))))
    else $error("result magnitude above 1.0");

endmodule

FILE: verif/dsc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Degree sine / cosine result checker
// Watches the input and output streams of the evaluator, predicts each result
// with a 64-bit fixed-point model of the series, and compares in order.
// ----------------------------------------------------------------------------
module dsc_checker #(
  parameter int unsigned SERIES_TERMS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [dsc_pkg::ANG_W-1:0]       s_tdata_i,
  input  logic [0:0]                      s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [dsc_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int                              errors_o,
  output int                              pending_o
);
  import dsc_pkg::*;

  localparam logic [63:0] RAD_PER_DEG = 64'd74961321;
  localparam logic [63:0] ONE_Q32     = 64'd1 << WORK_BITS;

  logic [OUT_TDATA_W-1:0] result_fifo[$];

  // Product shifted right by s, rounded half up.
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    if (s != 0) p = p + (128'd1 << (s - 1));
    q = p >> s;
    return q[63:0];
  endfunction

  // Floor integer square root.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bits;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x   = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Expected output word for one angle beat.
  function automatic logic [OUT_TDATA_W-1:0] sine_cosine_of(logic act, logic [31:0] raw);
    longint      ang;
    longint      period;
    longint      red;
    longint      sum;
    logic [63:0] theta;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] s_abs;
    logic [63:0] sq;
    logic [63:0] rad;
    logic [63:0] mag;
    logic        neg;
    logic [OUT_W-1:0] val;
    ang    = longint'($signed(raw));
    period = longint'(360) << FRAC_BITS;
    red    = ang % period;
    if (red < 0) red = red + period;
    if (red == 0 && ang > 0) red = period;
    theta = mul_round(64'(red), RAD_PER_DEG, FRAC_BITS);
    th2   = mul_round(theta, theta, WORK_BITS);
    term  = theta;
    sum   = 0;
    for (int i = 1; i <= SERIES_TERMS; i++) begin
      if (i % 2 == 1) sum = sum + longint'(term);
      else            sum = sum - longint'(term);
      term = mul_round(term, th2, WORK_BITS);
      term = term / 64'((2 * i) * (2 * i + 1));
    end
    // Cosine from the sine; a radicand below zero is clamped.
    if (act) begin
      s_abs = (sum < 0) ? 64'(-sum) : 64'(sum);
      sq    = mul_round(s_abs, s_abs, WORK_BITS);
      rad   = (sq >= ONE_Q32) ? 64'd0 : ONE_Q32 - sq;
      sum   = longint'((rad >= ONE_Q32) ? ONE_Q32 : floor_sqrt(rad << WORK_BITS));
      if (red > (longint'(90) << FRAC_BITS) && red < (longint'(270) << FRAC_BITS))
        sum = -sum;
    end
    // Round half away from zero and saturate to one.
    neg = sum < 0;
    mag = neg ? 64'(-sum) : 64'(sum);
    mag = (mag + (64'd1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS);
    if (mag > (64'd1 << FRAC_BITS)) mag = 64'd1 << FRAC_BITS;
    val = neg ? OUT_W'(-mag) : OUT_W'(mag);
    return OUT_TDATA_W'(val);
  endfunction

  assign pending_o = result_fifo.size();

  // Predict on every input beat and compare on every output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_TDATA_W-1:0] want;
    if (!rst_ni) begin
      errors_o = 0;
      result_fifo.delete();
    end else begin
      if (s_tvalid_i && s_tready_i)
        result_fifo.push_back(sine_cosine_of(s_tuser_i[0], s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, m_tdata_i);
          errors_o = errors_o + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want !== m_tdata_i) begin
            $display("%0t: value mismatch, expected %h, actual %h", $time, want, m_tdata_i);
            errors_o = errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_degree_sine_cosine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Degree sine / cosine evaluator testbench
// Drives directed and random angles under several idling patterns and lets
// the checker compare every result with its prediction.
// ----------------------------------------------------------------------------
module tb_degree_sine_cosine_top;
  import dsc_pkg::*;

  localparam int unsigned LATENCY = 97;
  localparam logic [31:0] DEG     = 32'd65536;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ANG_W-1:0]       s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     errors;
  int                     pending;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  bit                     hold_request = 0;
  int                     hold_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  degree_sine_cosine_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  dsc_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one angle beat and wait for it to be taken.
  task automatic send_angle(logic act, logic [31:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ang;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random angle: any 32-bit value, within two turns of zero, near a multiple of 90 degrees, or spread widely.
  function automatic logic [31:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(3);
    case (pick)
      0: return $urandom();
      1: return 32'($signed($urandom_range(1440)) - 720) * DEG + $urandom_range(65535);
      2: return 32'($signed($urandom_range(16)) - 8) * 90 * DEG
                + 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(2000000)) - 1000000) * 1000
                      + $urandom_range(999);
    endcase
  endfunction

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) send_angle($urandom_range(1), random_angle());
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 90 * DEG, 180 * DEG, 270 * DEG, 360 * DEG, -(360 * DEG),
                 720 * DEG, 32'h7fffffff, 32'h80000000, 45 * DEG, 135 * DEG,
                 32'd1, 90 * DEG + 1, 270 * DEG - 1};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners, both actions, no idling.
    foreach (directed[k]) begin
      send_angle(1'b0, directed[k]);
      send_angle(1'b1, directed[k]);
    end

    run_random(200, 0, 0);
    run_random(150, 80, 0);
    run_random(150, 0, 80);

    // Long receiver hold-off while beats keep coming, so the input stalls.
    hold_request = 1;
    run_random(100, 0, 0);

    // Sender pause until the pipeline has drained.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    run_random(150, 35, 35);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_degree_sine_cosine_top passed");
    end else begin
      $display("tb_degree_sine_cosine_top failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40_000_000;
    $display("tb_degree_sine_cosine_top failed");
    $finish;
  end

endmodule
